// ===== src/dmn_pkg.sv =====
package dmn_pkg;

  localparam int DefaultNodes = 16;
  localparam int IdW          = 4;
  localparam int CountW       = 5;
  localparam int StampW       = 32;
  localparam int QueueDepth   = 2;
  localparam int InDataW      = 40;
  localparam int OutDataW     = 40;
  localparam int CfgIdxW      = 1;
  localparam int CfgDataW     = 5;

  localparam logic [StampW-1:0] ClockMax = '1;

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_PEER    = 2'd1,
    CMD_REPLY   = 2'd2,
    CMD_EXIT    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ACT_REQUEST = 2'd0,
    ACT_REPLY   = 2'd1,
    ACT_GRANT   = 2'd2
  } act_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MY_ID      = 1'd0,
    REG_NODE_COUNT = 1'd1
  } reg_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [StampW-1:0] ts;
    logic [IdW-1:0]    sender;
  } dmn_entry_t;

  typedef struct packed {
    logic [IdW-1:0]    my_id;
    logic [CountW-1:0] active;
  } dmn_cfg_t;

  function automatic logic [StampW-1:0] sat_inc(input logic [StampW-1:0] v);
    return (v == ClockMax) ? ClockMax : v + 1'b1;
  endfunction

  // clamp node count into 2 .. cap
  function automatic logic [CountW-1:0] active_nodes(input logic [CountW-1:0] cnt,
                                                     input logic [CountW-1:0] cap);
    logic [CountW-1:0] n;
    n = cnt;
    if (n < CountW'(2)) n = CountW'(2);
    if (n > cap) n = cap;
    return n;
  endfunction

endpackage

// ===== src/dmn_fifo.sv =====
module dmn_fifo
  import dmn_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  dmn_entry_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output dmn_entry_t pop_data_o,
  output logic       empty_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  dmn_entry_t        mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o     = (count_q == CntW'(QueueDepth));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("queue count beyond depth");

endmodule

// ===== src/dmn_front.sv =====
module dmn_front
  import dmn_pkg::*;
#(
  parameter int NODES = DefaultNodes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dmn_entry_t          in_entry_i,
  output logic                push_o,
  output dmn_entry_t          push_data_o,
  input  logic                full_i,
  output dmn_cfg_t            cfg_o
);

  localparam logic [CountW-1:0] NodeCap = CountW'((NODES < 16) ? NODES : 16);

  logic [IdW-1:0]    my_id_q;
  logic [CountW-1:0] node_count_q;
  logic [CountW-1:0] active;
  logic              drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_id_q      <= '0;
      node_count_q <= CountW'(2);
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_MY_ID:      my_id_q      <= cfg_data_i[IdW-1:0];
        REG_NODE_COUNT: node_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign active       = active_nodes(node_count_q, NodeCap);
  assign cfg_o.my_id  = my_id_q;
  assign cfg_o.active = active;

  // peer requests from self or from outside the group never reach the back end
  assign drop = (in_entry_i.cmd == CMD_PEER) &&
                ((in_entry_i.sender == my_id_q) || ({1'b0, in_entry_i.sender} >= active));

  assign in_ready_o  = !full_i;
  assign push_o      = in_valid_i && !full_i && !drop;
  assign push_data_o = in_entry_i;

endmodule

// ===== src/dmn_back.sv =====
module dmn_back
  import dmn_pkg::*;
#(
  parameter int NODES = DefaultNodes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dmn_cfg_t          cfg_i,
  input  logic              empty_i,
  input  dmn_entry_t        entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output act_e              out_act_o,
  output logic [IdW-1:0]    out_dest_o,
  output logic [StampW-1:0] out_stamp_o,
  output logic              out_last_o
);

  localparam int DefW = (NODES < 16) ? NODES : 16;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e            state_q, state_d;
  logic [StampW-1:0] clock_q, clock_d;
  logic [StampW-1:0] stamp_q, stamp_d;
  logic              requesting_q, requesting_d;
  logic [IdW-1:0]    owed_q, owed_d;
  logic [DefW-1:0]   deferred_q, deferred_d;
  logic [DefW-1:0]   pend_q, pend_d;
  act_e              scan_act_q, scan_act_d;
  logic              out_valid_q, out_valid_d;
  act_e              out_act_q, out_act_d;
  logic [IdW-1:0]    out_dest_q, out_dest_d;
  logic [StampW-1:0] out_stamp_q, out_stamp_d;
  logic              out_last_q, out_last_d;

  logic              can_emit;
  logic [DefW-1:0]   peer_mask;
  logic [DefW-1:0]   sender_sel;
  logic [DefW-1:0]   pend_rest;
  logic [DefW-1:0]   exit_mask;
  logic [IdW-1:0]    low_id;
  logic              id_in_group;
  logic              mine;
  logic [StampW-1:0] clock_inc;
  logic [StampW-1:0] clock_max;

  always_comb begin
    for (int j = 0; j < DefW; j++) begin
      peer_mask[j]  = (CountW'(j) < cfg_i.active) && (IdW'(j) != cfg_i.my_id);
      sender_sel[j] = (entry_i.sender == IdW'(j));
    end
  end

  // lowest pending node goes out first
  always_comb begin
    low_id = '0;
    for (int j = DefW - 1; j >= 0; j--) begin
      if (pend_q[j]) low_id = IdW'(j);
    end
  end

  assign pend_rest   = pend_q & (pend_q - {{(DefW-1){1'b0}}, 1'b1});
  assign exit_mask   = deferred_q & peer_mask;
  assign id_in_group = ({1'b0, cfg_i.my_id} < cfg_i.active);
  assign clock_inc   = sat_inc(clock_q);
  assign clock_max   = (clock_q > entry_i.ts) ? clock_q : entry_i.ts;
  assign mine        = requesting_q &&
                       ((entry_i.ts > stamp_q) ||
                        ((entry_i.ts == stamp_q) && (cfg_i.my_id < entry_i.sender)));
  assign can_emit    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    clock_d      = clock_q;
    stamp_d      = stamp_q;
    requesting_d = requesting_q;
    owed_d       = owed_q;
    deferred_d   = deferred_q;
    pend_d       = pend_q;
    scan_act_d   = scan_act_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_act_d    = out_act_q;
    out_dest_d   = out_dest_q;
    out_stamp_d  = out_stamp_q;
    out_last_d   = out_last_q;
    pop_o        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i && can_emit) begin
          pop_o = 1'b1;
          unique case (entry_i.cmd)
            CMD_REQUEST: begin
              if (!requesting_q) begin
                requesting_d = 1'b1;
                clock_d      = clock_inc;
                stamp_d      = clock_inc;
                owed_d       = IdW'(cfg_i.active - {{(CountW-1){1'b0}}, id_in_group});
                pend_d       = peer_mask;
                scan_act_d   = ACT_REQUEST;
                state_d      = ST_SCAN;
              end
            end
            CMD_PEER: begin
              if (mine) begin
                deferred_d = deferred_q | sender_sel;
              end else begin
                deferred_d  = deferred_q & ~sender_sel;
                out_valid_d = 1'b1;
                out_act_d   = ACT_REPLY;
                out_dest_d  = entry_i.sender;
                out_stamp_d = '0;
                out_last_d  = 1'b1;
              end
              clock_d = sat_inc(clock_max);
            end
            CMD_REPLY: begin
              if (requesting_q && (owed_q != '0)) begin
                owed_d = owed_q - 1'b1;
                if (owed_q == IdW'(1)) begin
                  out_valid_d = 1'b1;
                  out_act_d   = ACT_GRANT;
                  out_dest_d  = '0;
                  out_stamp_d = '0;
                  out_last_d  = 1'b1;
                end
              end
            end
            CMD_EXIT: begin
              requesting_d = 1'b0;
              owed_d       = '0;
              deferred_d   = '0;
              if (exit_mask != '0) begin
                pend_d     = exit_mask;
                scan_act_d = ACT_REPLY;
                state_d    = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_act_d   = scan_act_q;
          out_dest_d  = low_id;
          out_stamp_d = (scan_act_q == ACT_REQUEST) ? stamp_q : '0;
          out_last_d  = (pend_rest == '0);
          pend_d      = pend_rest;
          if (pend_rest == '0) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      clock_q      <= '0;
      stamp_q      <= '0;
      requesting_q <= 1'b0;
      owed_q       <= '0;
      deferred_q   <= '0;
      pend_q       <= '0;
      scan_act_q   <= ACT_REQUEST;
      out_valid_q  <= 1'b0;
      out_act_q    <= ACT_REQUEST;
      out_dest_q   <= '0;
      out_stamp_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      clock_q      <= clock_d;
      stamp_q      <= stamp_d;
      requesting_q <= requesting_d;
      owed_q       <= owed_d;
      deferred_q   <= deferred_d;
      pend_q       <= pend_d;
      scan_act_q   <= scan_act_d;
      out_valid_q  <= out_valid_d;
      out_act_q    <= out_act_d;
      out_dest_q   <= out_dest_d;
      out_stamp_q  <= out_stamp_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_act_o   = out_act_q;
  assign out_dest_o  = out_dest_q;
  assign out_stamp_o = out_stamp_q;
  assign out_last_o  = out_last_q;

  a_scan_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (pend_q != '0))
    else $error("scan state with nothing pending");

  a_owed_needs_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (owed_q != '0) |-> requesting_q)
    else $error("replies owed while not requesting");

  a_stamp_not_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stamp_q <= clock_q)
    else $error("request stamp ahead of clock");

endmodule

// ===== src/distributed_mutex_node_unit.sv =====
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tuser: command; tdata: msg_timestamp, msg_sender
// m_axis    out  tvalid/tready, tlast   tuser: action; tdata: dest_node, stamp
// cfg       in   cfg_we_i               cfg_idx_i selects my_id or node_count
//
// a request is written into the queue, then the back end decodes it from the queue head
// peer request, peer reply and exit without deferred replies finish with that decode
// request entry and exit then emit up to 15 messages, one per cycle if not stalled,
// paced by the back-end scan of the pending node mask
// reset clears clock, stamps, deferred bits, queue and output register
// a stalled output holds the back end; the front keeps taking requests until the queue fills
module distributed_mutex_node_unit
  import dmn_pkg::*;
#(
  parameter int NODES = DefaultNodes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // msg_timestamp[31:0], msg_sender[35:32]
  input  logic [1:0]          s_axis_tuser_i,   // command[1:0]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // dest_node[3:0], stamp[35:4]
  output logic [1:0]          m_axis_tuser_o,   // action[1:0]
  output logic                m_axis_tlast_o
);

  dmn_entry_t        in_entry;
  dmn_entry_t        push_data;
  dmn_entry_t        pop_data;
  dmn_cfg_t          cfg;
  logic              push, pop, full, empty;
  act_e              out_act;
  logic [IdW-1:0]    out_dest;
  logic [StampW-1:0] out_stamp;

  assign in_entry.cmd    = cmd_e'(s_axis_tuser_i);
  assign in_entry.ts     = s_axis_tdata_i[StampW-1:0];
  assign in_entry.sender = s_axis_tdata_i[StampW +: IdW];

  dmn_front #(
    .NODES(NODES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_entry_i  (in_entry),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full),
    .cfg_o       (cfg)
  );

  dmn_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  dmn_back #(
    .NODES(NODES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .empty_i     (empty),
    .entry_i     (pop_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_act_o   (out_act),
    .out_dest_o  (out_dest),
    .out_stamp_o (out_stamp),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = out_act;
  assign m_axis_tdata_o = {{(OutDataW-IdW-StampW){1'b0}}, out_stamp, out_dest};

endmodule
